### rtl/core/bounded_byte_stream_fifo_top_macros.svh
// Assertion macros shared by the byte stream FIFO modules.
// Depends on a clk and an active-low rst_n in the using module.
`ifndef BOUNDED_BYTE_STREAM_FIFO_TOP_MACROS_SVH
`define BOUNDED_BYTE_STREAM_FIFO_TOP_MACROS_SVH

// Check a condition at every edge outside reset.
`define BBSF_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the cycle after it.
`define BBSF_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

### rtl/core/bbsf_pkg.sv
// Types and constants for the bounded byte stream FIFO.
// No dependencies; used by bbsf_ctrl and bounded_byte_stream_fifo_top.
package bbsf_pkg;

  localparam int CNT_W   = 13;
  localparam int TOTAL_W = 48;
  localparam int BYTE_W  = 8;
  localparam int OP_W    = 2;

  localparam logic [CNT_W-1:0] CAP_RESET = 13'd4096;

  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_POP   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLOSE = 2'd2;
  localparam logic [OP_W-1:0] OP_ERROR = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] data_byte;
    logic [CNT_W-1:0]  pop_count;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic               head_valid;
    logic [BYTE_W-1:0]  head_byte;
    logic [CNT_W-1:0]   buffered_count;
    logic [CNT_W-1:0]   free_count;
    logic [TOTAL_W-1:0] pushed_total;
    logic [TOTAL_W-1:0] popped_total;
    logic               closed;
    logic               finished;
    logic               error_flag;
  } out_item_t;

  // Status of one transfer, everything but the head byte from memory.
  typedef struct packed {
    logic               accepted;
    logic               head_valid;
    logic [CNT_W-1:0]   buffered_count;
    logic [CNT_W-1:0]   free_count;
    logic [TOTAL_W-1:0] pushed_total;
    logic [TOTAL_W-1:0] popped_total;
    logic               closed;
    logic               finished;
    logic               error_flag;
  } stat_t;

endpackage

### rtl/core/bbsf_ram.sv
// Byte store: one write port, one read port, registered read data.
// Write-first on a same-address collision. No package dependency.
module bbsf_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Forward the byte being written when the read hits the same entry.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/bbsf_ctrl.sv
// Pointer, count, total and flag update for the byte stream FIFO.
// Depends on bbsf_pkg and the assertion macro header.
`include "bounded_byte_stream_fifo_top_macros.svh"

module bbsf_ctrl #(
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [bbsf_pkg::CNT_W-1:0]   cfg_wr_data,
  input  logic                         item_acc,
  input  bbsf_pkg::in_item_t           item,
  output logic                         mem_wr_en,
  output logic [AW-1:0]                mem_wr_addr,
  output logic [bbsf_pkg::BYTE_W-1:0]  mem_wr_data,
  output logic                         mem_rd_en,
  output logic [AW-1:0]                mem_rd_addr,
  output bbsf_pkg::stat_t              stat
);
  import bbsf_pkg::*;

  logic [CNT_W-1:0]   cap_r;
  logic [AW-1:0]      rd_r, rd_nxt;
  logic [AW-1:0]      wr_r, wr_nxt;
  logic [CNT_W-1:0]   held_r, held_nxt;
  logic [TOTAL_W-1:0] pushed_r, pushed_nxt;
  logic [TOTAL_W-1:0] popped_r, popped_nxt;
  logic               closed_r, closed_nxt;
  logic               error_r, error_nxt;
  stat_t              stat_r, stat_nxt;

  logic [CNT_W-1:0]   cap_eff;
  logic               push_ok;
  logic [CNT_W-1:0]   pop_n;
  logic [CNT_W-1:0]   free_nxt;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p,
                                             input logic [CNT_W-1:0] n);
    logic [AW:0] s;
    s = (AW+1)'(p) + (AW+1)'(n);
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  always_comb begin
    cap_eff = (32'(cap_r) > DEPTH) ? CNT_W'(DEPTH) : cap_r;
    push_ok = (item.operation == OP_PUSH) && !closed_r && (held_r < cap_eff);
    pop_n   = (item.pop_count < held_r) ? item.pop_count : held_r;

    rd_nxt     = rd_r;
    wr_nxt     = wr_r;
    held_nxt   = held_r;
    pushed_nxt = pushed_r;
    popped_nxt = popped_r;
    closed_nxt = closed_r;
    error_nxt  = error_r;

    case (item.operation)
      OP_PUSH: begin
        if (push_ok) begin
          wr_nxt     = wrap_add(wr_r, CNT_W'(1));
          held_nxt   = held_r + CNT_W'(1);
          pushed_nxt = pushed_r + TOTAL_W'(1);
        end
      end
      OP_POP: begin
        rd_nxt     = wrap_add(rd_r, pop_n);
        held_nxt   = held_r - pop_n;
        popped_nxt = popped_r + TOTAL_W'(pop_n);
      end
      OP_CLOSE: closed_nxt = 1'b1;
      OP_ERROR: error_nxt  = 1'b1;
      default: ;
    endcase

    free_nxt = (cap_eff > held_nxt) ? (cap_eff - held_nxt) : '0;

    stat_nxt.accepted       = push_ok;
    stat_nxt.head_valid     = (held_nxt != '0);
    stat_nxt.buffered_count = held_nxt;
    stat_nxt.free_count     = free_nxt;
    stat_nxt.pushed_total   = pushed_nxt;
    stat_nxt.popped_total   = popped_nxt;
    stat_nxt.closed         = closed_nxt;
    stat_nxt.finished       = closed_nxt && (held_nxt == '0);
    stat_nxt.error_flag     = error_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r     <= '0;
      wr_r     <= '0;
      held_r   <= '0;
      pushed_r <= '0;
      popped_r <= '0;
      closed_r <= 1'b0;
      error_r  <= 1'b0;
    end else if (item_acc) begin
      rd_r     <= rd_nxt;
      wr_r     <= wr_nxt;
      held_r   <= held_nxt;
      pushed_r <= pushed_nxt;
      popped_r <= popped_nxt;
      closed_r <= closed_nxt;
      error_r  <= error_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc) begin
      stat_r <= stat_nxt;
    end
  end

  // Read the head at the pointer left by this transfer.
  assign mem_wr_en   = item_acc && push_ok;
  assign mem_wr_addr = wr_r;
  assign mem_wr_data = item.data_byte;
  assign mem_rd_en   = item_acc;
  assign mem_rd_addr = rd_nxt;
  assign stat        = stat_r;

  `BBSF_ASSERT(a_held_bound, 32'(held_r) <= DEPTH, "held count exceeds depth")
  `BBSF_ASSERT(a_no_write_closed, !(mem_wr_en && closed_r), "write after close")
  `BBSF_ASSERT_NEXT(a_push_total, mem_wr_en,
                    pushed_r == $past(pushed_r) + TOTAL_W'(1), "pushed total did not advance")

endmodule

### rtl/core/bounded_byte_stream_fifo_top.sv
// Top level of the bounded byte stream FIFO with close and error marks.
// Depends on bbsf_pkg, bbsf_ctrl, bbsf_ram and the assertion macro header.
//
// Usage:
//   Input channel in_valid / in_stall / in_item carries one operation per
//   transfer: push a byte, pop a count of bytes, close the stream or set the
//   error mark. Every accepted transfer yields exactly one status transfer on
//   out_valid / out_stall / out_item, in order.
//   cfg_wr_en / cfg_wr_data write the capacity register; write it only while
//   no transfer is in flight. Capacities above DEPTH act as DEPTH.
// Pipeline:
//   A transfer accepted at one edge updates the counters, pointers and
//   status and reads the new head from the byte store at that same edge
//   (the read stage); the output register then merges the head byte with
//   the status. One transfer per cycle is sustained while out_stall stays
//   low; a stalled output holds the flow as described under Stall.
// Reset (rst_n low, synchronous): pointers, counts, totals and flags clear,
//   capacity returns to 4096, both pipeline slots empty. The byte store keeps
//   its contents; only written entries are ever shown.
// Stall: a stalled status holds in the output register; one more transfer may
//   enter and wait in the read stage, after which in_stall rises.
`include "bounded_byte_stream_fifo_top_macros.svh"

module bounded_byte_stream_fifo_top #(
  parameter int DEPTH = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [bbsf_pkg::CNT_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  bbsf_pkg::in_item_t         in_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output bbsf_pkg::out_item_t        out_item
);
  import bbsf_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic              item_acc;
  logic              mem_wr_en;
  logic [AW-1:0]     mem_wr_addr;
  logic [BYTE_W-1:0] mem_wr_data;
  logic              mem_rd_en;
  logic [AW-1:0]     mem_rd_addr;
  logic [BYTE_W-1:0] mem_rd_data;
  stat_t             stat;

  logic              s1_valid_r, s1_valid_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r;
  logic              out_load;

  // Stall only when the read stage is full and cannot drain.
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign item_acc = in_valid && !in_stall;
  assign out_load = s1_valid_r && (!out_valid_r || !out_stall);

  bbsf_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_acc    (item_acc),
    .item        (in_item),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .stat        (stat)
  );

  bbsf_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  always_comb begin
    s1_valid_nxt  = item_acc || (s1_valid_r && !out_load);
    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Merge the head byte from memory with the registered status; zero when empty.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.accepted       <= stat.accepted;
      out_r.head_valid     <= stat.head_valid;
      out_r.head_byte      <= stat.head_valid ? mem_rd_data : '0;
      out_r.buffered_count <= stat.buffered_count;
      out_r.free_count     <= stat.free_count;
      out_r.pushed_total   <= stat.pushed_total;
      out_r.popped_total   <= stat.popped_total;
      out_r.closed         <= stat.closed;
      out_r.finished       <= stat.finished;
      out_r.error_flag     <= stat.error_flag;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `BBSF_ASSERT(a_head_matches_count,
               !out_valid_r || (out_r.head_valid == (out_r.buffered_count != '0)),
               "head valid disagrees with count")
  `BBSF_ASSERT(a_finished_empty,
               !(out_valid_r && out_r.finished && (out_r.buffered_count != '0)),
               "finished with bytes held")
  `BBSF_ASSERT(a_kept_nonempty,
               !(out_valid_r && out_r.accepted && !out_r.head_valid),
               "kept byte but buffer empty")

endmodule

### bench/fifo_status_check_pkg.sv
// Status predictor and scoreboard for the bounded byte stream FIFO bench.
// Depends on bbsf_pkg for the transfer types and operation codes.
package fifo_status_check_pkg;

  import bbsf_pkg::*;

  localparam int FIFO_DEPTH = 4096;

  class fifo_status_scoreboard;

    bit [BYTE_W-1:0]  byte_mem [FIFO_DEPTH];
    bit [11:0]        rd_ptr;
    bit [11:0]        wr_ptr;
    bit [CNT_W-1:0]   held;
    bit [CNT_W-1:0]   cap;
    bit [TOTAL_W-1:0] pushed;
    bit [TOTAL_W-1:0] popped;
    bit               closed_m;
    bit               error_m;
    out_item_t        expected_status[$];
    int unsigned      failures;

    function new();
      rd_ptr   = '0;
      wr_ptr   = '0;
      held     = '0;
      cap      = CAP_RESET;
      pushed   = '0;
      popped   = '0;
      closed_m = 1'b0;
      error_m  = 1'b0;
      failures = 0;
    endfunction

    function void set_capacity(bit [CNT_W-1:0] value);
      cap = value;
    endfunction

    function int unsigned held_bytes();
      return 32'(held);
    endfunction

    function int unsigned pending();
      return expected_status.size();
    endfunction

    // Apply one accepted operation and queue the status it must produce.
    function void note_transfer(in_item_t it);
      bit [CNT_W-1:0] eff;
      bit [CNT_W-1:0] n;
      out_item_t      s;
      eff = (cap > CNT_W'(FIFO_DEPTH)) ? CNT_W'(FIFO_DEPTH) : cap;
      s   = '0;
      case (it.operation)
        OP_PUSH: begin
          if (!closed_m && held < eff) begin
            byte_mem[wr_ptr] = it.data_byte;
            wr_ptr     = wr_ptr + 12'd1;
            held       = held + CNT_W'(1);
            pushed     = pushed + TOTAL_W'(1);
            s.accepted = 1'b1;
          end
        end
        OP_POP: begin
          n      = (it.pop_count < held) ? it.pop_count : held;
          rd_ptr = rd_ptr + n[11:0];
          held   = held - n;
          popped = popped + TOTAL_W'(n);
        end
        OP_CLOSE: closed_m = 1'b1;
        OP_ERROR: error_m  = 1'b1;
        default: ;
      endcase
      s.head_valid     = (held != '0);
      s.head_byte      = (held != '0) ? byte_mem[rd_ptr] : '0;
      s.buffered_count = held;
      s.free_count     = (eff > held) ? eff - held : '0;
      s.pushed_total   = pushed;
      s.popped_total   = popped;
      s.closed         = closed_m;
      s.finished       = closed_m && (held == '0);
      s.error_flag     = error_m;
      expected_status.push_back(s);
    endfunction

    function void flag_field(string name, logic [TOTAL_W-1:0] want, logic [TOTAL_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_status(out_item_t got);
      out_item_t want;
      if (expected_status.size() == 0) begin
        $display("%0t: status transfer with none expected, expected none, actual %h",
                 $time, got);
        failures++;
        return;
      end
      want = expected_status[0];
      expected_status.delete(0);
      flag_field("accepted", TOTAL_W'(want.accepted), TOTAL_W'(got.accepted));
      flag_field("head_valid", TOTAL_W'(want.head_valid), TOTAL_W'(got.head_valid));
      flag_field("head_byte", TOTAL_W'(want.head_byte), TOTAL_W'(got.head_byte));
      flag_field("buffered_count", TOTAL_W'(want.buffered_count),
                 TOTAL_W'(got.buffered_count));
      flag_field("free_count", TOTAL_W'(want.free_count), TOTAL_W'(got.free_count));
      flag_field("pushed_total", want.pushed_total, got.pushed_total);
      flag_field("popped_total", want.popped_total, got.popped_total);
      flag_field("closed", TOTAL_W'(want.closed), TOTAL_W'(got.closed));
      flag_field("finished", TOTAL_W'(want.finished), TOTAL_W'(got.finished));
      flag_field("error_flag", TOTAL_W'(want.error_flag), TOTAL_W'(got.error_flag));
    endfunction

  endclass

endpackage

### bench/tb_top.sv
// Top-level bench for bounded_byte_stream_fifo_top: directed and random operations.
// Depends on bbsf_pkg, fifo_status_check_pkg and the FIFO RTL.
module tb_top;

  import bbsf_pkg::*;
  import fifo_status_check_pkg::*;

  // Clock and reset; every input starts at a known value.
  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             cfg_wr_en   = 1'b0;
  logic [CNT_W-1:0] cfg_wr_data = '0;
  logic             in_valid    = 1'b0;
  logic             in_stall;
  in_item_t         in_item     = '0;
  logic             out_valid;
  logic             out_stall   = 1'b0;
  out_item_t        out_item;

  // Idle percentages for the sender gap and the receiver stall.
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;

  fifo_status_scoreboard sb;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  bounded_byte_stream_fifo_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

  // Receiver: stall at random, one decision per edge.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Monitor: every status transfer is checked against the oldest prediction.
  // Values read here are the ones present at the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_status(out_item);
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #1600000;
    $display("[bounded_byte_stream_fifo_top] ERROR");
    $finish;
  end

  function automatic in_item_t make_op(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data,
                                       logic [CNT_W-1:0] count);
    in_item_t it;
    it.operation = op;
    it.data_byte = data;
    it.pop_count = count;
    return it;
  endfunction

  // Present one operation, hold it until the block takes it, then predict.
  task automatic send_transfer(in_item_t it);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_transfer(it);
  endtask

  task automatic send_op(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data,
                         logic [CNT_W-1:0] count);
    send_transfer(make_op(op, data, count));
  endtask

  // Drop valid and wait until every predicted status has come back.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Write capacity only with nothing in flight; let the pipeline settle first.
  task automatic write_capacity(logic [CNT_W-1:0] value);
    hold_until_drained();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_capacity(value);
  endtask

  task automatic set_idling(int unsigned gap, int unsigned stall);
    gap_pct   = gap;
    stall_pct = stall;
  endtask

  // Random operations: pushes and pops dominate so the buffer keeps filling
  // and draining; fields start as random bits, and most pops then pick the count.
  task automatic run_random(int unsigned n, int unsigned push_pct, bit allow_close);
    in_item_t    it;
    int unsigned r;
    int unsigned pick;
    repeat (n) begin
      it.data_byte = BYTE_W'($urandom);
      it.pop_count = CNT_W'($urandom);
      r = $urandom_range(0, 99);
      if (r < push_pct) begin
        it.operation = OP_PUSH;
      end else if (r < 97) begin
        it.operation = OP_POP;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          it.pop_count = CNT_W'($urandom_range(0, 3));
        end else if (pick == 7) begin
          it.pop_count = CNT_W'(sb.held_bytes());
        end else if (pick == 8) begin
          it.pop_count = CNT_W'(FIFO_DEPTH);
        end
      end else if (r == 99 && allow_close) begin
        it.operation = OP_CLOSE;
      end else begin
        it.operation = OP_ERROR;
      end
      send_transfer(it);
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pops, repeated error mark, byte extremes, limited pops.
    send_op(OP_POP, 8'h00, 13'd0);
    send_op(OP_POP, 8'hFF, 13'd8191);
    send_op(OP_ERROR, 8'h12, 13'd5);
    send_op(OP_ERROR, 8'h34, 13'd0);
    send_op(OP_PUSH, 8'h00, 13'd0);
    send_op(OP_PUSH, 8'hFF, 13'd0);
    send_op(OP_PUSH, 8'hA5, 13'd8191);
    send_op(OP_POP, 8'hFF, 13'd0);
    send_op(OP_POP, 8'h00, 13'd1);
    send_op(OP_POP, 8'h00, 13'd4096);
    send_op(OP_PUSH, 8'h3C, 13'd0);

    // Zero capacity drops every push.
    write_capacity(13'd0);
    send_op(OP_PUSH, 8'h99, 13'd0);

    // Small capacity: fill, then drop at full.
    write_capacity(13'd2);
    send_op(OP_PUSH, 8'h55, 13'd0);
    send_op(OP_PUSH, 8'h66, 13'd0);
    send_op(OP_POP, 8'hFF, 13'd0);

    // Capacity below what is held: nothing is lost, pushes are dropped until there is room.
    write_capacity(13'd1);
    send_op(OP_PUSH, 8'h11, 13'd0);
    send_op(OP_POP, 8'h00, 13'd1);
    send_op(OP_PUSH, 8'h22, 13'd0);
    send_op(OP_POP, 8'h00, 13'd1);
    send_op(OP_PUSH, 8'h77, 13'd0);

    // Capacity above the store depth saturates.
    write_capacity(13'd8191);
    send_op(OP_PUSH, 8'h88, 13'd0);

    // Random phases, one idling pattern each.
    write_capacity(13'd8);
    set_idling(0, 0);
    run_random(200, 60, 1'b0);

    write_capacity(CNT_W'($urandom_range(1, 16)));
    set_idling(62, 0);
    run_random(125, 60, 1'b0);
    // Pressure: pause the sender until every status has come back.
    hold_until_drained();
    run_random(125, 60, 1'b0);

    write_capacity(13'd0);
    set_idling(0, 62);
    run_random(60, 60, 1'b0);
    write_capacity(13'd3);
    run_random(250, 55, 1'b0);

    write_capacity(CAP_RESET);
    set_idling(7, 7);
    run_random(250, 70, 1'b0);

    // Push a burst with the capacity saturated, then empty the buffer in one
    // oversized pop; keep going at random.
    write_capacity(13'd8191);
    set_idling(0, 0);
    repeat (64) send_op(OP_PUSH, BYTE_W'($urandom), CNT_W'($urandom));
    send_op(OP_POP, BYTE_W'($urandom), 13'd4096);
    set_idling(62, 62);
    run_random(200, 60, 1'b0);

    // Lower the capacity well below a partly full buffer.
    write_capacity(13'd4095);
    set_idling(0, 62);
    run_random(20, 100, 1'b0);
    write_capacity(13'd5);
    run_random(200, 50, 1'b0);

    // Close: repeated close, pushes dropped after it, drain to finished.
    write_capacity(13'd6);
    set_idling(0, 0);
    send_op(OP_PUSH, 8'hC3, 13'd0);
    send_op(OP_PUSH, 8'h3C, 13'd0);
    send_op(OP_CLOSE, 8'h00, 13'd0);
    send_op(OP_CLOSE, 8'hFF, 13'd8191);
    send_op(OP_PUSH, 8'hEE, 13'd0);
    send_op(OP_POP, 8'h00, 13'd1);
    send_op(OP_POP, 8'h00, 13'd8191);
    send_op(OP_PUSH, 8'h01, 13'd0);
    set_idling(62, 62);
    run_random(120, 50, 1'b1);

    // Wait out the last statuses, then keep the clock running to catch any stray transfer.
    hold_until_drained();
    repeat (8) @(posedge clk);
    if (sb.failures == 0) begin
      $display("[bounded_byte_stream_fifo_top] OK");
    end else begin
      $display("[bounded_byte_stream_fifo_top] ERROR");
    end
    $finish;
  end

endmodule
